// ===== src/rled_pkg.sv =====
`default_nettype none

package rled_pkg;

    // Longest run before it is closed and restarted
    localparam int MAX_RUN       = 65535;
    localparam int COUNT_BITS    = 16;
    localparam int LENGTH_BITS   = 32;
    // Decimal digits needed for a count up to MAX_RUN
    localparam int DIGITS        = 5;
    localparam int NDIG_BITS     = 3;
    // Command queue between the run tracker and the digit emitter
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    typedef logic [DIGITS-1:0][3:0] bcd_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       item_end;
        logic       string_end;
        logic       use_original;
    } result_t;

    // One closed run to be written out as symbol plus decimal count
    typedef struct packed {
        logic [7:0]             symbol;
        bcd_t                   bcd;
        logic [NDIG_BITS-1:0]   ndig;
        logic                   item_end;
        logic                   string_end;
        logic [LENGTH_BITS-1:0] orig_len;
    } cmd_t;

    // Up to two commands produced by one accepted word
    typedef struct packed {
        logic a_valid;
        logic b_valid;
        cmd_t a;
        cmd_t b;
    } cmd_push_t;

    function automatic bcd_t bcd_inc(input bcd_t v);
        bcd_t r;
        logic c;
        r = v;
        c = 1'b1;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (c)
            begin
                if (r[i] == 4'd9)
                begin
                    r[i] = 4'd0;
                end
                else
                begin
                    r[i] = r[i] + 4'd1;
                    c = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // Number of significant digits, at least one
    function automatic logic [NDIG_BITS-1:0] bcd_ndig(input bcd_t v);
        logic [NDIG_BITS-1:0] n;
        n = NDIG_BITS'(1);
        for (int i = 1; i < DIGITS; i++)
        begin
            if (v[i] != 4'd0)
            begin
                n = NDIG_BITS'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
        return (v == LEN_MAX) ? LEN_MAX : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== src/rled_front.sv =====
`default_nettype none

module rled_front
    import rled_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      accept,
    input  wire item_t     item,
    output cmd_push_t      cmds
);

    logic [7:0]             run_sym_reg,  run_sym_next;
    logic [COUNT_BITS-1:0]  run_cnt_reg,  run_cnt_next;
    bcd_t                   run_bcd_reg,  run_bcd_next;
    logic                   run_open_reg, run_open_next;
    logic [LENGTH_BITS-1:0] orig_reg,     orig_next;

    logic                   extend;
    logic [LENGTH_BITS-1:0] orig_inc;
    logic [7:0]             new_sym;
    logic [COUNT_BITS-1:0]  new_cnt;
    bcd_t                   new_bcd;

    // Classify the word: extend the open run or close it and start anew
    always_comb
    begin
        orig_inc = sat_inc(orig_reg);
        extend   = run_open_reg && (item.symbol == run_sym_reg)
                   && (run_cnt_reg < COUNT_BITS'(MAX_RUN));
        if (extend)
        begin
            new_sym = run_sym_reg;
            new_cnt = run_cnt_reg + 1'b1;
            new_bcd = bcd_inc(run_bcd_reg);
        end
        else
        begin
            new_sym = item.symbol;
            new_cnt = COUNT_BITS'(1);
            new_bcd = bcd_t'(1);
        end

        // Close the previous run
        cmds.a_valid      = accept && run_open_reg && !extend;
        cmds.a.symbol     = run_sym_reg;
        cmds.a.bcd        = run_bcd_reg;
        cmds.a.ndig       = bcd_ndig(run_bcd_reg);
        cmds.a.item_end   = !item.last;
        cmds.a.string_end = 1'b0;
        cmds.a.orig_len   = orig_inc;

        // Close the run left open at the end of the string
        cmds.b_valid      = accept && item.last;
        cmds.b.symbol     = new_sym;
        cmds.b.bcd        = new_bcd;
        cmds.b.ndig       = bcd_ndig(new_bcd);
        cmds.b.item_end   = 1'b1;
        cmds.b.string_end = 1'b1;
        cmds.b.orig_len   = orig_inc;

        run_sym_next  = run_sym_reg;
        run_cnt_next  = run_cnt_reg;
        run_bcd_next  = run_bcd_reg;
        run_open_next = run_open_reg;
        orig_next     = orig_reg;
        if (accept)
        begin
            if (item.last)
            begin
                run_sym_next  = '0;
                run_cnt_next  = '0;
                run_bcd_next  = '0;
                run_open_next = 1'b0;
                orig_next     = '0;
            end
            else
            begin
                run_sym_next  = new_sym;
                run_cnt_next  = new_cnt;
                run_bcd_next  = new_bcd;
                run_open_next = 1'b1;
                orig_next     = orig_inc;
            end
        end
    end

    // Hold the run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_sym_reg  <= '0;
            run_cnt_reg  <= '0;
            run_bcd_reg  <= '0;
            run_open_reg <= 1'b0;
            orig_reg     <= '0;
        end
        else
        begin
            run_sym_reg  <= run_sym_next;
            run_cnt_reg  <= run_cnt_next;
            run_bcd_reg  <= run_bcd_next;
            run_open_reg <= run_open_next;
            orig_reg     <= orig_next;
        end
    end

    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        run_open_reg |-> (run_cnt_reg != '0 && run_cnt_reg <= COUNT_BITS'(MAX_RUN)))
        else $error("open run with count out of range");

    a_closed_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !run_open_reg |-> (run_cnt_reg == '0 && run_bcd_reg == '0))
        else $error("closed run left a count behind");

endmodule

`default_nettype wire

// ===== src/rled_cmd_fifo.sv =====
`default_nettype none

module rled_cmd_fifo
    import rled_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmd_push_t cmds,
    input  wire logic      pop,
    output logic           room2,
    output logic           head_valid,
    output cmd_t           head
);

    cmd_t                     mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg,  count_next;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_plus;
    logic [1:0]               npush;
    cmd_t                     e0;

    // Pack up to two commands into consecutive slots
    always_comb
    begin
        wr_ptr_plus = wr_ptr_reg + 1'b1;
        npush       = {1'b0, cmds.a_valid} + {1'b0, cmds.b_valid};
        e0          = cmds.a_valid ? cmds.a : cmds.b;
        wr_ptr_next = wr_ptr_reg + npush;
        rd_ptr_next = rd_ptr_reg + {{(FIFO_PTR_BITS-1){1'b0}}, pop};
        count_next  = count_reg + {{(FIFO_CNT_BITS-2){1'b0}}, npush}
                      - {{(FIFO_CNT_BITS-1){1'b0}}, pop};
        room2       = count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 2);
        head_valid  = count_reg != '0;
        head        = mem[rd_ptr_reg];
    end

    // Write the slots
    always_ff @(posedge clk)
    begin
        if (npush != 2'd0)
        begin
            mem[wr_ptr_reg] <= e0;
        end
        if (npush == 2'd2)
        begin
            mem[wr_ptr_plus] <= cmds.b;
        end
    end

    // Advance the pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("command queue popped while empty");

endmodule

`default_nettype wire

// ===== src/rled_back.sv =====
`default_nettype none

module rled_back
    import rled_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  head_valid,
    input  wire cmd_t  head,
    output logic       cmd_pop,
    output logic       empty,
    input  wire logic  pop,
    output result_t    result
);

    logic [NDIG_BITS-1:0]   pos_reg,  pos_next;
    logic [LENGTH_BITS-1:0] comp_reg, comp_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg;
    result_t                word;
    logic                   advance;
    logic                   done;
    logic [NDIG_BITS-1:0]   dig_idx;
    logic [3:0]             digit;
    logic [LENGTH_BITS-1:0] comp_inc;

    // One word per cycle unless stalled: the symbol, then digits MSB first
    always_comb
    begin
        advance  = head_valid && (!out_valid_reg || pop);
        done     = pos_reg == head.ndig;
        dig_idx  = head.ndig - pos_reg;
        case (dig_idx)
            3'd0:    digit = head.bcd[0];
            3'd1:    digit = head.bcd[1];
            3'd2:    digit = head.bcd[2];
            3'd3:    digit = head.bcd[3];
            3'd4:    digit = head.bcd[4];
            default: digit = 4'd0;
        endcase
        comp_inc = sat_inc(comp_reg);

        word.out_symbol   = (pos_reg == '0) ? head.symbol : (ASCII_ZERO | {4'd0, digit});
        word.item_end     = done && head.item_end;
        word.string_end   = done && head.string_end;
        word.use_original = done && head.string_end && (comp_inc >= head.orig_len);

        cmd_pop        = advance && done;
        pos_next       = pos_reg;
        comp_next      = comp_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            pos_next       = done ? '0 : pos_reg + 1'b1;
            comp_next      = word.string_end ? '0 : comp_inc;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        empty  = !out_valid_reg;
        result = out_reg;
    end

    // Hold the output word
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> pos_reg <= head.ndig)
        else $error("digit position past the count");

    a_string_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && word.string_end) |=> comp_reg == '0)
        else $error("compressed length not cleared at end of string");

endmodule

`default_nettype wire

// ===== src/run_length_encode_decimal.sv =====
`default_nettype none

// Run-length encoder with decimal counts. Bytes of a string are pushed one
// per word, with last set on the final byte. Each closed run comes out as its
// symbol followed by the count in ASCII decimal, most significant digit first;
// runs longer than 65535 are split. The final word of a string carries
// string_end and use_original, which is set when the encoded form is not
// shorter than the original. A byte is taken whenever the internal
// four-entry command queue has room for two commands; the output side
// produces one word per cycle while a command waits and the output word is
// free or popped, writing a run as its symbol word and one word per digit.
// A closed run is held first in the command queue and then in the output
// word register before it reaches the outputs.
module run_length_encode_decimal
    import rled_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    output logic         full,
    input  wire item_t   item,
    output logic         empty,
    input  wire logic    pop,
    output result_t      result
);

    cmd_push_t cmds;
    logic      room2;
    logic      head_valid;
    cmd_t      head;
    logic      cmd_pop;
    logic      accept;

    assign full   = !room2;
    assign accept = push && room2;

    rled_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cmds   (cmds)
    );

    rled_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmds       (cmds),
        .pop        (cmd_pop),
        .room2      (room2),
        .head_valid (head_valid),
        .head       (head)
    );

    rled_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .cmd_pop    (cmd_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire
